FILE: rtl/pds_pkg.sv
package pds_pkg;

    localparam int unsigned MOTOR_SWAP_RUN = 10;

    // Reciprocal for the run division; exact for every 10-bit count
    localparam int unsigned RECIP_SHIFT = 32;
    localparam logic [32:0] SWAP_RECIP =
        33'(((64'(1) << RECIP_SHIFT) + 64'(MOTOR_SWAP_RUN) - 64'(1)) / 64'(MOTOR_SWAP_RUN));

    localparam int unsigned COUNT_W = 10;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned POINT_W = 16;
    localparam int unsigned ADD_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MODULUS = 10'd1000;

    localparam logic [POINT_W-1:0] GIFT_COST_RST    = 16'd100;
    localparam logic [COUNT_W-1:0] START_COUNT_RST  = 10'd0;
    localparam logic [TIME_W-1:0]  FEED_TIMEOUT_RST = 16'd30000;
    localparam logic [TIME_W-1:0]  RELEASE_WAIT_RST = 16'd200;
    localparam logic [TIME_W-1:0]  GAP_TIME_RST     = 16'd1000;
    localparam logic [TIME_W-1:0]  ERROR_REPEAT_RST = 16'd30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GIFT_COST    = 3'd0,
        REG_DUAL_MOTOR   = 3'd1,
        REG_START_COUNT  = 3'd2,
        REG_FEED_TIMEOUT = 3'd3,
        REG_RELEASE_WAIT = 3'd4,
        REG_GAP_TIME     = 3'd5,
        REG_ERROR_REPEAT = 3'd6
    } cfg_index_t;

    typedef enum logic [7:0] {
        PH_WAIT_SCORE  = 8'b0000_0001,
        PH_START_MOTOR = 8'b0000_0010,
        PH_WAIT_BEAM   = 8'b0000_0100,
        PH_CONFIRM     = 8'b0000_1000,
        PH_RELEASE     = 8'b0001_0000,
        PH_GAP         = 8'b0010_0000,
        PH_ERR_WAIT    = 8'b0100_0000,
        PH_ERR_ANNOUNCE = 8'b1000_0000
    } phase_t;

    // Bit 0 of count / MOTOR_SWAP_RUN
    function automatic logic swap_bit(input logic [COUNT_W-1:0] count);
        logic [COUNT_W+32:0] product;
        product = (COUNT_W + 33)'(count) * (COUNT_W + 33)'(SWAP_RECIP);
        return product[RECIP_SHIFT];
    endfunction

    function automatic logic [COUNT_W-1:0] wrap_count(input logic [COUNT_W-1:0] count);
        return (count >= COUNT_MODULUS) ? count - COUNT_MODULUS : count;
    endfunction

endpackage

FILE: rtl/prize_dispense_sequencer.sv
// Prize chute sequencer.
// Input channel (s_valid/s_ready): one word per 1 ms tick, carrying the chute
// beam level (0 = prize in beam) and the points earned during that tick.
// Result channel (m_valid/m_ready): one word per input word with the motor
// drive, motor choice, one-tick sound/display/store requests, the gift count
// and the remaining score after that tick.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
// one register written per handshake; write only while the block is idle.
// Result: the result of a tick is on the m_ port in the cycle after its input
// word is accepted. Throughput: one word per cycle while m_ready is high, set
// by the single output register that the tick's state update loads.
// Stall: while m_ready is low and a result waits, s_ready drops; a new word
// is taken in the same cycle the waiting result is taken.
// Reset (aresetn low, synchronous): config registers return to their defaults,
// the sequencer waits for score, the count loads the default start count and
// the output register empties.
module prize_dispense_sequencer
    import pds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_sensor_level,
    input  logic [ADD_W-1:0]      s_score_add,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_motor_on,
    output logic                  m_motor_select,
    output logic                  m_sound_gift,
    output logic                  m_sound_error,
    output logic                  m_error_display,
    output logic                  m_count_store,
    output logic [COUNT_W-1:0]    m_gift_count,
    output logic                  m_score_show,
    output logic [POINT_W-1:0]    m_score,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [POINT_W-1:0] gift_cost_reg;
    logic               dual_motor_reg;
    logic [TIME_W-1:0]  feed_timeout_reg;
    logic [TIME_W-1:0]  release_wait_reg;
    logic [TIME_W-1:0]  gap_time_reg;
    logic [TIME_W-1:0]  error_repeat_reg;

    phase_t             phase_reg, phase_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [POINT_W-1:0] points_reg, points_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               spare_reg, spare_next;
    logic               motor_reg, motor_next;

    logic               m_valid_reg;
    logic               gift_reg, gift_next;
    logic               err_snd_reg, err_snd_next;
    logic               store_reg, store_next;
    logic               show_reg, show_next;

    logic               accept;
    logic               cfg_write;
    logic [TIME_W:0]    tick;
    logic [TIME_W-1:0]  tick_sat;
    logic [COUNT_W-1:0] count_inc;
    logic [POINT_W-1:0] charged;
    logic [POINT_W:0]   sum;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    assign tick      = {1'b0, elapsed_reg} + (TIME_W + 1)'(1);
    assign tick_sat  = tick[TIME_W] ? '1 : tick[TIME_W-1:0];
    assign count_inc = count_reg + COUNT_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        spare_next   = spare_reg;
        motor_next   = motor_reg;
        charged      = points_reg;
        gift_next    = 1'b0;
        err_snd_next = 1'b0;
        store_next   = 1'b0;
        show_next    = 1'b0;

        unique case (phase_reg)
            PH_WAIT_SCORE: begin
                if (points_reg >= gift_cost_reg) begin
                    phase_next = PH_START_MOTOR;
                end
            end
            PH_START_MOTOR: begin
                count_next   = count_inc;
                spare_next   = dual_motor_reg ? swap_bit(count_inc) : 1'b0;
                motor_next   = 1'b1;
                elapsed_next = '0;
                phase_next   = PH_WAIT_BEAM;
            end
            PH_WAIT_BEAM: begin
                if (!s_sensor_level) begin
                    elapsed_next = '0;
                    phase_next   = PH_CONFIRM;
                end else begin
                    elapsed_next = tick_sat;
                    // timeout: drop the motor and latch the error
                    if (tick > {1'b0, feed_timeout_reg}) begin
                        motor_next = 1'b0;
                        phase_next = PH_ERR_ANNOUNCE;
                    end
                end
            end
            PH_CONFIRM: begin
                if (!s_sensor_level) begin
                    gift_next    = 1'b1;
                    elapsed_next = '0;
                    phase_next   = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                elapsed_next = tick_sat;
                if (tick >= {1'b0, release_wait_reg} && s_sensor_level) begin
                    motor_next   = 1'b0;
                    elapsed_next = '0;
                    phase_next   = PH_GAP;
                    count_next   = wrap_count(count_reg);
                    store_next   = 1'b1;
                end
            end
            PH_GAP: begin
                elapsed_next = tick_sat;
                if (tick >= {1'b0, gap_time_reg}) begin
                    charged    = (points_reg >= gift_cost_reg) ?
                                 points_reg - gift_cost_reg : '0;
                    show_next  = 1'b1;
                    phase_next = PH_WAIT_SCORE;
                end
            end
            PH_ERR_WAIT: begin
                elapsed_next = tick_sat;
                if (tick > {1'b0, error_repeat_reg}) begin
                    phase_next = PH_ERR_ANNOUNCE;
                end
            end
            PH_ERR_ANNOUNCE: begin
                err_snd_next = 1'b1;
                elapsed_next = '0;
                phase_next   = PH_ERR_WAIT;
            end
            default: begin
                phase_next = PH_WAIT_SCORE;
            end
        endcase

        // add this tick's points, saturating
        sum         = {1'b0, charged} + (POINT_W + 1)'(s_score_add);
        points_next = sum[POINT_W] ? '1 : sum[POINT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gift_cost_reg    <= GIFT_COST_RST;
            dual_motor_reg   <= 1'b0;
            feed_timeout_reg <= FEED_TIMEOUT_RST;
            release_wait_reg <= RELEASE_WAIT_RST;
            gap_time_reg     <= GAP_TIME_RST;
            error_repeat_reg <= ERROR_REPEAT_RST;
            phase_reg        <= PH_WAIT_SCORE;
            elapsed_reg      <= '0;
            points_reg       <= '0;
            count_reg        <= START_COUNT_RST;
            spare_reg        <= 1'b0;
            motor_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                points_reg  <= points_next;
                count_reg   <= count_next;
                spare_reg   <= spare_next;
                motor_reg   <= motor_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_GIFT_COST:    gift_cost_reg    <= cfg_data;
                    REG_DUAL_MOTOR:   dual_motor_reg   <= cfg_data[0];
                    REG_START_COUNT:  count_reg        <= cfg_data[COUNT_W-1:0];
                    REG_FEED_TIMEOUT: feed_timeout_reg <= cfg_data;
                    REG_RELEASE_WAIT: release_wait_reg <= cfg_data;
                    REG_GAP_TIME:     gap_time_reg     <= cfg_data;
                    REG_ERROR_REPEAT: error_repeat_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // result word payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            gift_reg    <= gift_next;
            err_snd_reg <= err_snd_next;
            store_reg   <= store_next;
            show_reg    <= show_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_motor_on      = motor_reg;
    assign m_motor_select  = spare_reg;
    assign m_sound_gift    = gift_reg;
    assign m_sound_error   = err_snd_reg;
    assign m_error_display = err_snd_reg;
    assign m_count_store   = store_reg;
    assign m_gift_count    = count_reg;
    assign m_score_show    = show_reg;
    assign m_score         = points_reg;

`ifndef SYNTHESIS
    a_gift_with_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sound_gift |-> m_motor_on)
        else $error("gift sound without motor running");

    a_store_motor_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count_store |-> !m_motor_on && (m_gift_count < COUNT_MODULUS))
        else $error("count stored with motor on or out of range");

    a_pulses_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_sound_gift, m_sound_error, m_count_store, m_score_show}))
        else $error("more than one request pulse in one word");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word produced no result");
`endif

endmodule

FILE: sim/tb_prize_dispense_sequencer.sv
`timescale 1ns / 100ps

module tb_prize_dispense_sequencer;
    import pds_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PLAN_LEN    = 29;

    typedef struct packed {
        logic               motor_on;
        logic               motor_select;
        logic               sound_gift;
        logic               sound_error;
        logic               error_display;
        logic               count_store;
        logic [COUNT_W-1:0] gift_count;
        logic               score_show;
        logic [POINT_W-1:0] score;
    } chute_word_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        cfg_index_t              reg_sel;
        logic [CFG_DATA_W-1:0]   data;
        logic                    sensor;
        logic [ADD_W-1:0]        add;
        logic                    pinned;
        chute_word_t             word;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_sensor_level;
    logic [ADD_W-1:0]      s_score_add;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_motor_on;
    logic                  m_motor_select;
    logic                  m_sound_gift;
    logic                  m_sound_error;
    logic                  m_error_display;
    logic                  m_count_store;
    logic [COUNT_W-1:0]    m_gift_count;
    logic                  m_score_show;
    logic [POINT_W-1:0]    m_score;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    prize_dispense_sequencer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_level  (s_sensor_level),
        .s_score_add     (s_score_add),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_motor_on      (m_motor_on),
        .m_motor_select  (m_motor_select),
        .m_sound_gift    (m_sound_gift),
        .m_sound_error   (m_sound_error),
        .m_error_display (m_error_display),
        .m_count_store   (m_count_store),
        .m_gift_count    (m_gift_count),
        .m_score_show    (m_score_show),
        .m_score         (m_score),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Chute predictor: settings and sequencing state
    logic [POINT_W-1:0] cost_r;
    logic               dual_r;
    logic [TIME_W-1:0]  feed_to_r;
    logic [TIME_W-1:0]  release_r;
    logic [TIME_W-1:0]  gap_r;
    logic [TIME_W-1:0]  repeat_r;
    phase_t             ph;
    logic [TIME_W-1:0]  elapsed_q;
    logic [POINT_W-1:0] points_q;
    logic [COUNT_W-1:0] count_q;
    logic               spare_q;
    logic               motor_q;

    chute_word_t expected_words[$];
    plan_row_t   plan [PLAN_LEN];

    logic calm = 1'b0;
    int   cycle_count = 0;
    int   fail_count = 0;
    int   tick_count = 0;
    int   reg_writes = 0;
    int   words_checked = 0;
    int   prizes = 0;
    int   spare_prizes = 0;
    int   alarms = 0;

    task automatic reset_chute();
        cost_r    = 16'd100;
        dual_r    = 1'b0;
        feed_to_r = 16'd30000;
        release_r = 16'd200;
        gap_r     = 16'd1000;
        repeat_r  = 16'd30000;
        ph        = PH_WAIT_SCORE;
        elapsed_q = '0;
        points_q  = '0;
        count_q   = '0;
        spare_q   = 1'b0;
        motor_q   = 1'b0;
    endtask

    task automatic apply_setting(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GIFT_COST:    cost_r = data;
            REG_DUAL_MOTOR:   dual_r = data[0];
            REG_START_COUNT:  count_q = data[COUNT_W-1:0];
            REG_FEED_TIMEOUT: feed_to_r = data;
            REG_RELEASE_WAIT: release_r = data;
            REG_GAP_TIME:     gap_r = data;
            REG_ERROR_REPEAT: repeat_r = data;
            default: ;
        endcase
    endtask

    // Advance the phase timer; return the count before saturation
    function automatic logic [TIME_W:0] bump_timer();
        logic [TIME_W:0] nxt;
        nxt = {1'b0, elapsed_q} + 17'd1;
        elapsed_q = nxt[TIME_W] ? 16'hFFFF : nxt[TIME_W-1:0];
        return nxt;
    endfunction

    function automatic chute_word_t step_chute(input logic sensor, input logic [ADD_W-1:0] add);
        chute_word_t     w;
        logic [TIME_W:0] t;
        logic [POINT_W:0] sum;
        w = '0;
        case (ph)
            PH_WAIT_SCORE: begin
                if (points_q >= cost_r) ph = PH_START_MOTOR;
            end
            PH_START_MOTOR: begin
                count_q   = count_q + 10'd1;
                spare_q   = dual_r && (((count_q / MOTOR_SWAP_RUN) % 2) != 0);
                motor_q   = 1'b1;
                elapsed_q = '0;
                ph        = PH_WAIT_BEAM;
            end
            PH_WAIT_BEAM: begin
                if (!sensor) begin
                    elapsed_q = '0;
                    ph        = PH_CONFIRM;
                end else begin
                    t = bump_timer();
                    if (t > {1'b0, feed_to_r}) begin
                        motor_q = 1'b0;
                        ph      = PH_ERR_ANNOUNCE;
                    end
                end
            end
            PH_CONFIRM: begin
                if (!sensor) begin
                    w.sound_gift = 1'b1;
                    elapsed_q    = '0;
                    ph           = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                t = bump_timer();
                if (t >= {1'b0, release_r} && sensor) begin
                    motor_q       = 1'b0;
                    elapsed_q     = '0;
                    ph            = PH_GAP;
                    count_q       = COUNT_W'(count_q % 10'd1000);
                    w.count_store = 1'b1;
                end
            end
            PH_GAP: begin
                t = bump_timer();
                if (t >= {1'b0, gap_r}) begin
                    points_q     = (points_q >= cost_r) ? points_q - cost_r : '0;
                    w.score_show = 1'b1;
                    ph           = PH_WAIT_SCORE;
                end
            end
            PH_ERR_WAIT: begin
                t = bump_timer();
                if (t > {1'b0, repeat_r}) ph = PH_ERR_ANNOUNCE;
            end
            default: begin
                w.sound_error   = 1'b1;
                w.error_display = 1'b1;
                elapsed_q       = '0;
                ph              = PH_ERR_WAIT;
            end
        endcase
        sum      = {1'b0, points_q} + (POINT_W + 1)'(add);
        points_q = sum[POINT_W] ? 16'hFFFF : sum[POINT_W-1:0];
        w.motor_on     = motor_q;
        w.motor_select = spare_q;
        w.gift_count   = count_q;
        w.score        = points_q;
        return w;
    endfunction

    function automatic plan_row_t row_tick(input logic sensor, input logic [ADD_W-1:0] add);
        plan_row_t r;
        r = '0;
        r.kind   = ROW_TICK;
        r.sensor = sensor;
        r.add    = add;
        return r;
    endfunction

    function automatic plan_row_t row_write(input cfg_index_t idx, input logic [15:0] data);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_WRITE;
        r.reg_sel = idx;
        r.data    = data;
        return r;
    endfunction

    // Tick row whose result word is known by inspection
    function automatic plan_row_t row_pin(input logic sensor, input logic [ADD_W-1:0] add,
                                          input logic motor, input logic sel, input logic gift,
                                          input logic store, input logic [COUNT_W-1:0] count,
                                          input logic show, input logic [POINT_W-1:0] score);
        plan_row_t r;
        r = row_tick(sensor, add);
        r.pinned             = 1'b1;
        r.word.motor_on      = motor;
        r.word.motor_select  = sel;
        r.word.sound_gift    = gift;
        r.word.count_store   = store;
        r.word.gift_count    = count;
        r.word.score_show    = show;
        r.word.score         = score;
        return r;
    endfunction

    function automatic logic [15:0] timer_pick(input int unsigned lo, input int unsigned hi);
        return ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(hi, lo));
    endfunction

    // Called at a rising edge; returns after its word is taken
    task automatic feed_tick(input logic sensor, input logic [ADD_W-1:0] add,
                             input logic pinned, input chute_word_t pinned_word);
        chute_word_t predicted;
        s_valid        <= 1'b1;
        s_sensor_level <= sensor;
        s_score_add    <= add;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = step_chute(sensor, add);
        expected_words.push_back(pinned ? pinned_word : predicted);
        tick_count++;
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Hold input until every result has drained, then write one register
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_setting(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic retune();
        write_reg(REG_GIFT_COST, 16'($urandom_range(300, 1)));
        write_reg(REG_DUAL_MOTOR, 16'($urandom_range(1, 0)));
        write_reg(REG_START_COUNT,
                  ($urandom_range(0, 3) == 0) ? 16'd999 : 16'($urandom_range(999, 0)));
        write_reg(REG_FEED_TIMEOUT, timer_pick(1, 40));
        write_reg(REG_RELEASE_WAIT, timer_pick(0, 20));
        write_reg(REG_GAP_TIME, timer_pick(0, 20));
        write_reg(REG_ERROR_REPEAT, timer_pick(1, 20));
    endtask

    // Shape the beam so most feeds complete; jam the chute when asked
    task automatic random_tick(input logic hoard, input logic jam);
        logic             sensor;
        logic [ADD_W-1:0] add;
        case (ph)
            PH_WAIT_BEAM: sensor = ($urandom_range(0, 99) >= 25);
            PH_CONFIRM:   sensor = ($urandom_range(0, 99) >= 80);
            PH_RELEASE: begin
                if ({1'b0, elapsed_q} + 17'd1 < {1'b0, release_r})
                    sensor = ($urandom_range(0, 99) >= 80);
                else
                    sensor = ($urandom_range(0, 99) < 60);
            end
            default: sensor = ($urandom_range(0, 99) < 90);
        endcase
        if ($urandom_range(0, 9) == 0) sensor = 1'($urandom_range(1, 0));
        if (ph == PH_WAIT_BEAM) begin
            if (jam)
                sensor = 1'b1;
            else if ({1'b0, elapsed_q} + 17'd1 > {1'b0, feed_to_r})
                sensor = 1'b0;
        end
        if (hoard)
            add = 8'hFF;
        else if ($urandom_range(0, 4) == 0)
            add = 8'($urandom_range(255, 0));
        else
            add = 8'($urandom_range(12, 0));
        feed_tick(sensor, add, 1'b0, '0);
    endtask

    task automatic flag_field(input string name, input logic [15:0] want, input logic [15:0] got);
        $error("%s: expected %0d, got %0d", name, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        chute_word_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word arrived with nothing expected");
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (want.sound_gift) prizes++;
                if (want.count_store && want.motor_select) spare_prizes++;
                if (want.sound_error) alarms++;
                if (m_motor_on !== want.motor_on)
                    flag_field("motor_on", 16'(want.motor_on), 16'(m_motor_on));
                if (m_motor_select !== want.motor_select)
                    flag_field("motor_select", 16'(want.motor_select), 16'(m_motor_select));
                if (m_sound_gift !== want.sound_gift)
                    flag_field("sound_gift", 16'(want.sound_gift), 16'(m_sound_gift));
                if (m_sound_error !== want.sound_error)
                    flag_field("sound_error", 16'(want.sound_error), 16'(m_sound_error));
                if (m_error_display !== want.error_display)
                    flag_field("error_display", 16'(want.error_display), 16'(m_error_display));
                if (m_count_store !== want.count_store)
                    flag_field("count_store", 16'(want.count_store), 16'(m_count_store));
                if (m_gift_count !== want.gift_count)
                    flag_field("gift_count", 16'(want.gift_count), 16'(m_gift_count));
                if (m_score_show !== want.score_show)
                    flag_field("score_show", 16'(want.score_show), 16'(m_score_show));
                if (m_score !== want.score)
                    flag_field("score", want.score, m_score);
            end
        end
        m_ready <= calm || ($urandom_range(0, 99) >= 12);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_sensor_level <= 1'b1;
        s_score_add    <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_GIFT_COST;
        cfg_data       <= '0;
        reset_chute();

        plan = '{
            row_pin(1'b1, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'd0),
            row_pin(1'b1, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'd255),
            row_write(REG_FEED_TIMEOUT, 16'd3),
            row_write(REG_RELEASE_WAIT, 16'd0),
            row_write(REG_GAP_TIME, 16'd0),
            row_write(REG_START_COUNT, 16'd999),
            row_write(REG_DUAL_MOTOR, 16'd1),
            row_tick(1'b1, 8'd0),
            // count steps past 999 before the store folds it back
            row_pin(1'b1, 8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 10'd1000, 1'b0, 16'd255),
            row_tick(1'b0, 8'd0),
            row_pin(1'b0, 8'd0,   1'b1, 1'b0, 1'b1, 1'b0, 10'd1000, 1'b0, 16'd255),
            row_tick(1'b0, 8'd7),
            row_pin(1'b1, 8'd0,   1'b0, 1'b0, 1'b0, 1'b1, 10'd0, 1'b0, 16'd262),
            row_pin(1'b1, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b1, 16'd162),
            row_write(REG_START_COUNT, 16'd9),
            row_tick(1'b1, 8'd0),
            row_pin(1'b1, 8'd0,   1'b1, 1'b1, 1'b0, 1'b0, 10'd10, 1'b0, 16'd162),
            // hold the beam clear right up to the feed limit
            row_tick(1'b1, 8'd0),
            row_tick(1'b1, 8'd0),
            row_tick(1'b1, 8'd0),
            row_tick(1'b0, 8'd0),
            row_tick(1'b1, 8'd0),
            row_tick(1'b0, 8'd0),
            row_tick(1'b1, 8'd0),
            // cost raised during the gap: charge floors at zero
            row_write(REG_GIFT_COST, 16'hFFFF),
            row_pin(1'b1, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 10'd10, 1'b1, 16'd0),
            row_write(REG_GIFT_COST, 16'd1),
            row_tick(1'b1, 8'd255),
            row_tick(1'b1, 8'd255)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].reg_sel, plan[i].data);
            else
                feed_tick(plan[i].sensor, plan[i].add, plan[i].pinned, plan[i].word);
        end

        for (int seg = 0; seg < 7; seg++) begin
            calm = (seg == 3);
            retune();
            repeat (150) random_tick(1'b0, 1'b0);
        end
        calm = 1'b0;

        // saturate the score against the top cost
        write_reg(REG_GIFT_COST, 16'hFFFF);
        write_reg(REG_FEED_TIMEOUT, 16'hFFFF);
        write_reg(REG_RELEASE_WAIT, 16'd0);
        write_reg(REG_GAP_TIME, 16'd0);
        write_reg(REG_DUAL_MOTOR, 16'd1);
        repeat (300) random_tick(1'b1, 1'b0);

        // jam the chute last: the error state never leaves
        write_reg(REG_GIFT_COST, 16'd1);
        write_reg(REG_FEED_TIMEOUT, 16'd1);
        write_reg(REG_ERROR_REPEAT, 16'd1);
        repeat (40) random_tick(1'b0, 1'b1);
        write_reg(REG_ERROR_REPEAT, 16'hFFFF);
        repeat (20) random_tick(1'b0, 1'b1);
        write_reg(REG_ERROR_REPEAT, 16'd4);
        repeat (40) random_tick(1'b0, 1'b1);

        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("tb: %0d ticks, %0d result words checked, %0d register writes",
                 tick_count, words_checked, reg_writes);
        $display("tb: %0d prizes (%0d on spare motor), %0d error announcements",
                 prizes, spare_prizes, alarms);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
